// ===== src/odo_pkg.sv =====
package odo_pkg;

    // Widths of the CORDIC working registers.
    localparam int XW = 35;
    localparam int ZW = 34;
    localparam int IW = 5;
    localparam int MAX_STEPS = 24;

    // Reset value of the turn gain register, Q8.16.
    localparam logic [23:0] TURN_GAIN_RST = 24'd67290;

    // CORDIC gain compensation 0.6072529 in Q0.16.
    localparam logic signed [16:0] CORDIC_GAIN = 17'sd39797;

    // Input transaction payload.
    typedef struct packed {
        logic signed [15:0] left_step;
        logic signed [15:0] right_step;
    } t_odo_in;

    // Output transaction payload.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [31:0] travelled;
    } t_odo_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic head;
        logic init;
        logic iter;
        logic acc;
        logic publish;
    } t_odo_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic iter_last;
    } t_odo_sts;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [ZW-1:0] atan_turn(input logic [IW-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Signed 32-bit add that clamps to the representable range.
    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/odo_ctrl.sv =====
module odo_ctrl import odo_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_odo_sts i_sts,
    output t_odo_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_HEAD = 3'd2;
    localparam logic [2:0] ST_INIT = 3'd3;
    localparam logic [2:0] ST_ITER = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_HEAD;
            end
            ST_HEAD: begin
                o_cmd.head = 1'b1;
                n_state    = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_ITER;
            end
            ST_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // The output register is free, or is emptied in this cycle.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid flag follows publish and output transactions.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/odo_dp.sv =====
module odo_dp import odo_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_odo_cmd    i_cmd,
    output t_odo_sts    o_sts,
    input  t_odo_in     i_in_data,
    input  logic [23:0] i_turn_gain,
    output t_odo_out    o_out_data
);

    localparam int NITER = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

    logic signed [15:0]   r_left;
    logic signed [15:0]   r_right;
    logic signed [15:0]   r_fwd;
    logic [15:0]          r_dh;
    logic [15:0]          r_heading;
    logic signed [31:0]   r_travel;
    logic signed [31:0]   r_x_acc;
    logic signed [31:0]   r_y_acc;
    logic signed [XW-1:0] r_cx;
    logic signed [XW-1:0] r_cy;
    logic signed [ZW-1:0] r_cz;
    logic [IW-1:0]        r_cnt;
    t_odo_out             r_out;

    logic signed [16:0]   w_sum;
    logic signed [16:0]   w_diff;
    logic signed [41:0]   w_prod;
    logic                 w_flip;
    logic [15:0]          w_hf;
    logic signed [16:0]   w_fwd_ext;
    logic signed [16:0]   w_fwd_f;
    logic signed [33:0]   w_x0;
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_atan;
    logic signed [XW-1:0] w_xr;
    logic signed [XW-1:0] w_yr;
    logic signed [31:0]   w_xinc;
    logic signed [31:0]   w_yinc;

    // Forward step and heading step from the wheel travel.
    assign w_sum  = $signed({r_left[15], r_left}) + $signed({r_right[15], r_right});
    assign w_diff = $signed({r_right[15], r_right}) - $signed({r_left[15], r_left});
    assign w_prod = w_diff * $signed({1'b0, i_turn_gain});

    // Fold the heading into the right half plane, negating the step to match.
    assign w_flip    = r_heading[15] ^ r_heading[14];
    assign w_hf      = {r_heading[15] ^ w_flip, r_heading[14:0]};
    assign w_fwd_ext = $signed({r_fwd[15], r_fwd});
    assign w_fwd_f   = w_flip ? -w_fwd_ext : w_fwd_ext;
    assign w_x0      = w_fwd_f * CORDIC_GAIN;

    // One CORDIC rotation step.
    assign w_xs   = r_cx >>> r_cnt;
    assign w_ys   = r_cy >>> r_cnt;
    assign w_atan = atan_turn(r_cnt);

    // Round the rotated vector to whole units, half way rounding up.
    assign w_xr   = r_cx + $signed(XW'(32768));
    assign w_yr   = r_cy + $signed(XW'(32768));
    assign w_xinc = $signed({{13{w_xr[XW-1]}}, w_xr[XW-1:16]});
    assign w_yinc = $signed({{13{w_yr[XW-1]}}, w_yr[XW-1:16]});

    // Accumulated state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_travel  <= '0;
            r_x_acc   <= '0;
            r_y_acc   <= '0;
        end else begin
            if (i_cmd.head) begin
                r_heading <= r_heading + r_dh;
                r_travel  <= sat_add32(r_travel, $signed({{16{r_fwd[15]}}, r_fwd}));
            end
            if (i_cmd.acc) begin
                r_x_acc <= sat_add32(r_x_acc, w_xinc);
                r_y_acc <= sat_add32(r_y_acc, w_yinc);
            end
        end
    end

    // Working registers of one update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= i_in_data.left_step;
            r_right <= i_in_data.right_step;
        end
        if (i_cmd.mul) begin
            r_fwd <= w_sum[16:1];
            r_dh  <= w_prod[31:16];
        end
        if (i_cmd.init) begin
            r_cx  <= XW'(w_x0);
            r_cy  <= '0;
            r_cz  <= $signed({{2{w_hf[15]}}, w_hf, 16'h0000});
            r_cnt <= '0;
        end else if (i_cmd.iter) begin
            if (!r_cz[ZW-1]) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.publish) begin
            r_out.pos_x     <= r_x_acc;
            r_out.pos_y     <= r_y_acc;
            r_out.heading   <= r_heading;
            r_out.travelled <= r_travel;
        end
    end

    assign o_sts.iter_last = (r_cnt == IW'(NITER - 1));
    assign o_out_data      = r_out;

endmodule

// ===== src/differential_drive_odometry.sv =====
// Channel  Direction  Handshake               Payload
// in       input      i_in_valid/o_in_ready    i_in_data  (t_odo_in)
// out      output     o_out_valid/i_out_ready  o_out_data (t_odo_out)
// cfg      input      i_cfg_valid/o_cfg_ready  i_cfg_data (turn gain, Q8.16)
//
// One update runs from the input transaction through the states MUL, HEAD, INIT, ITER
// and ACC to DONE, which writes the result to the output register; the iterative CORDIC
// rotator takes N steps in ITER, one step a cycle, N being the smaller of CORDIC_STEPS and 24.
// The next input is taken only once the controller is back in idle.
// Reset is synchronous and active low; it clears pose, distance and turn gain (67290).
// A full output register stalls the controller only once the next result is ready.
module differential_drive_odometry import odo_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_odo_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_odo_out    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    logic [23:0] r_turn_gain;
    t_odo_cmd    w_cmd;
    t_odo_sts    w_sts;

    // Turn gain register; a write is always taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_gain <= TURN_GAIN_RST;
        end else if (i_cfg_valid) begin
            r_turn_gain <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    odo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    odo_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_turn_gain (r_turn_gain),
        .o_out_data  (o_out_data)
    );

    // After an input transaction the block is busy with that update.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an update is in progress");

    // A new result appears only as the controller returns to idle.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result published while the controller is not idle");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ===== test/differential_drive_odometry_tb.sv =====
module differential_drive_odometry_tb import odo_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ROT_STEPS      = 16;
    localparam int     ROT_LIMIT      = 24;
    localparam longint GAIN_COMP      = 39797;
    localparam int     QUARTER_TURN   = 'h4000;
    localparam int     HALF_TURN      = 'h8000;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     PHASE_ITEMS    = 560;
    localparam int     STRAIGHT_ITEMS = 150;
    localparam int     SETTLE_CYCLES  = 40;

    typedef enum {ROW_ITEM, ROW_GAIN, ROW_AIM} t_row_kind;

    // One row of the directed table: an update, a gain write or a heading aim.
    typedef struct {
        t_row_kind          kind;
        logic [23:0]        arg;
        logic signed [15:0] left;
        logic signed [15:0] right;
        bit                 typed;
        t_odo_out           want;
    } t_dir_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_odo_in     i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_odo_out    o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data  = '0;

    // Predicted block state, starting from the reset values.
    logic [23:0]        gain_q = TURN_GAIN_RST;
    logic [15:0]        hdg_q  = '0;
    logic signed [31:0] trav_q = '0;
    logic signed [31:0] px_q   = '0;
    logic signed [31:0] py_q   = '0;

    // Arctangent of 2^-i in units of 2^-32 turn.
    longint atan_tbl [0:ROT_LIMIT-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    t_odo_out pose_q [$];
    t_dir_row dir_tbl [$];

    int err_cnt      = 0;
    int n_updates    = 0;
    int n_results    = 0;
    int n_gains      = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_token   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    differential_drive_odometry #(.CORDIC_STEPS(ROT_STEPS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Signed accumulate that clamps at the 32-bit rails.
    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] acc,
                                                     input longint step);
        longint s;
        s = acc + step;
        if (s > longint'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end
        if (s < longint'(32'sh8000_0000)) begin
            return 32'sh8000_0000;
        end
        return 32'(s);
    endfunction

    // Dead-reckoning update of the predicted pose for one tick.
    function automatic t_odo_out advance_pose(input t_odo_in stp);
        longint   lft, rgt, fwd, prod, gain_l, xr, yr, zr, xs, ys;
        int       ang;
        t_odo_out o;
        lft    = stp.left_step;
        rgt    = stp.right_step;
        gain_l = gain_q;
        fwd    = (lft + rgt) >>> 1;
        prod   = (rgt - lft) * gain_l;
        hdg_q  = hdg_q + 16'(prod >>> 16);
        trav_q = clamp_add(trav_q, fwd);

        // Fold the left half-plane onto the right one, then rotate.
        ang = hdg_q;
        if (((ang + QUARTER_TURN) & HALF_TURN) != 0) begin
            fwd = -fwd;
            ang = (ang - HALF_TURN) & 'hFFFF;
        end
        if (ang >= HALF_TURN) begin
            ang = ang - 65536;
        end
        zr = longint'(ang) * 65536;
        xr = fwd * GAIN_COMP;
        yr = 0;
        for (int k = 0; k < ROT_STEPS && k < ROT_LIMIT; k++) begin
            xs = xr >>> k;
            ys = yr >>> k;
            if (zr >= 0) begin
                xr = xr - ys;
                yr = yr + xs;
                zr = zr - atan_tbl[k];
            end else begin
                xr = xr + ys;
                yr = yr - xs;
                zr = zr + atan_tbl[k];
            end
        end
        px_q = clamp_add(px_q, (xr + 32768) >>> 16);
        py_q = clamp_add(py_q, (yr + 32768) >>> 16);

        o.pos_x     = px_q;
        o.pos_y     = py_q;
        o.heading   = hdg_q;
        o.travelled = trav_q;
        return o;
    endfunction

    // Random wheel steps: half full range, some small, some straight, some corners.
    function automatic t_odo_in rand_step();
        t_odo_in            s;
        logic signed [15:0] corner [4];
        corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                s.left_step  = 16'($urandom);
                s.right_step = 16'($urandom);
            end
            5, 6, 7: begin
                s.left_step  = 16'(int'($urandom_range(1023)) - 512);
                s.right_step = 16'(int'($urandom_range(1023)) - 512);
            end
            8: begin
                s.left_step  = 16'($urandom);
                s.right_step = s.left_step;
            end
            default: begin
                s.left_step  = corner[$urandom_range(3)];
                s.right_step = corner[$urandom_range(3)];
            end
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Offer one update tick; the pose is predicted when the transaction is accepted.
    task automatic send_step(input t_odo_in stp, input bit typed, input t_odo_out want);
        t_odo_out pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= stp;
        do @(posedge i_clk); while (!o_in_ready);
        pred = advance_pose(stp);
        pose_q.push_back(typed ? want : pred);
        n_updates++;
    endtask

    // Stop offering ticks and wait until every predicted pose has come out.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [23:0] g);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gain_q = g;
        n_gains++;
    endtask

    // With a gain of exactly one the wheel difference becomes the heading step,
    // so a single tick can put the heading on any target.
    task automatic aim_heading(input logic [15:0] target);
        t_odo_in stp;
        stp.left_step  = 16'sd0;
        stp.right_step = target - hdg_q;
        send_step(stp, 1'b0, '0);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic [23:0] g,
                             input int n, input bit hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        write_gain(g);
        for (int i = 0; i < n; i++) begin
            if (hold && i == n / 3) begin
                hold_token <= hold_token + 1;
            end
            send_step(rand_step(), 1'b0, '0);
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each output transaction with the oldest predicted pose.
    always @(posedge i_clk) begin
        t_odo_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pose_q.size() == 0) begin
                report_mismatch("pose with none pending, travelled", o_out_data.travelled, 0);
            end else begin
                want = pose_q.pop_front();
                if (o_out_data.pos_x !== want.pos_x) begin
                    report_mismatch("pos_x", o_out_data.pos_x, want.pos_x);
                end
                if (o_out_data.pos_y !== want.pos_y) begin
                    report_mismatch("pos_y", o_out_data.pos_y, want.pos_y);
                end
                if (o_out_data.heading !== want.heading) begin
                    report_mismatch("heading", o_out_data.heading, want.heading);
                end
                if (o_out_data.travelled !== want.travelled) begin
                    report_mismatch("travelled", o_out_data.travelled, want.travelled);
                end
            end
        end
    end

    // Count cycles in which no transaction of any channel completes.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("Watchdog: no transaction for %0d cycles, %0d poses outstanding",
                 WATCHDOG_LIMIT, pose_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_odo_in stp;

        // Directed table: reset state, wheel extremes, gain extremes, and the
        // heading put on and just below the quadrant boundaries of the rotator.
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sd0, 16'sd0, 1'b1,
                            '{32'sd0, 32'sd0, 16'h0000, 32'sd0}});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sd1, -16'sd1, 1'b1,
                            '{32'sd0, 32'sd0, 16'hFFFD, 32'sd0}});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, -16'sd1, 16'sd1, 1'b1,
                            '{32'sd0, 32'sd0, 16'hFFFF, 32'sd0}});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sh7FFF, 16'sh7FFF, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sh8000, 16'sh8000, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sh8000, 16'sh7FFF, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sh7FFF, 16'sh8000, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, -16'sd1, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_GAIN, 24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sh8000, 16'sh7FFF, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sd3, -16'sd5, 1'b0, '0});
        dir_tbl.push_back('{ROW_GAIN, 24'd0, 16'sd0, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sd12345, -16'sd23456, 1'b0, '0});
        dir_tbl.push_back('{ROW_GAIN, 24'h010000, 16'sd0, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_AIM, 24'h004000, 16'sd0, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sd20000, 16'sd20000, 1'b0, '0});
        dir_tbl.push_back('{ROW_AIM, 24'h008000, 16'sd0, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sd20000, 16'sd20000, 1'b0, '0});
        dir_tbl.push_back('{ROW_AIM, 24'h00C000, 16'sd0, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, -16'sd20000, -16'sd20000, 1'b0, '0});
        dir_tbl.push_back('{ROW_AIM, 24'h003FFF, 16'sd0, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, 16'sd20000, 16'sd20000, 1'b0, '0});
        dir_tbl.push_back('{ROW_AIM, 24'h00BFFF, 16'sd0, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{ROW_ITEM, 24'd0, -16'sd1, -16'sd1, 1'b0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs with the first idle pattern.
        tx_idle_pct = 20;
        rx_idle_pct <= 67;
        foreach (dir_tbl[r]) begin
            case (dir_tbl[r].kind)
                ROW_GAIN: begin
                    write_gain(dir_tbl[r].arg);
                end
                ROW_AIM: begin
                    aim_heading(dir_tbl[r].arg[15:0]);
                end
                default: begin
                    stp.left_step  = dir_tbl[r].left;
                    stp.right_step = dir_tbl[r].right;
                    send_step(stp, dir_tbl[r].typed, dir_tbl[r].want);
                end
            endcase
        end

        // Random phases: sender idles lightly, then receiver lightly, then no idling.
        run_phase(20, 67, 24'($urandom_range(24'hFFFFFF)), PHASE_ITEMS, 1'b1);
        run_phase(67, 20, TURN_GAIN_RST, PHASE_ITEMS, 1'b0);
        run_phase(0, 0, 24'($urandom_range(200000)), PHASE_ITEMS, 1'b0);

        // Drive straight ahead at full speed along x, then back up at full speed.
        write_gain(24'h010000);
        aim_heading(16'h0000);
        stp.left_step  = 16'sh7FFF;
        stp.right_step = 16'sh7FFF;
        repeat (STRAIGHT_ITEMS) send_step(stp, 1'b0, '0);
        stp.left_step  = 16'sh8000;
        stp.right_step = 16'sh8000;
        repeat (STRAIGHT_ITEMS) send_step(stp, 1'b0, '0);

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d odometry ticks and %0d poses under %0d turn gain writes,",
                 n_updates, n_results, n_gains);
        $display("with idling on both channels, a long output hold-off and full-speed runs.");
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
